>>> rtl/mlp2_pkg.sv
`default_nettype none
package mlp2_pkg;
    localparam int MAX_HIDDEN  = 32;
    localparam int MAX_INPUTS  = 32;
    localparam int MAX_OUTPUTS = 16;
    localparam int HW_DEPTH    = MAX_HIDDEN * MAX_INPUTS;
    localparam int OW_COLS     = MAX_HIDDEN + 1;
    localparam int OW_DEPTH    = MAX_OUTPUTS * OW_COLS;
    localparam int HW_AW       = $clog2(HW_DEPTH);
    localparam int OW_AW       = $clog2(OW_DEPTH);
    localparam int IV_AW       = $clog2(MAX_INPUTS);
    localparam int HA_AW       = $clog2(MAX_HIDDEN);
    localparam int ACC_W       = 56;

    localparam logic [1:0] CMD_HW = 2'd0;
    localparam logic [1:0] CMD_OW = 2'd1;
    localparam logic [1:0] CMD_IV = 2'd2;

    localparam logic [1:0] REG_HIDDEN = 2'd0;
    localparam logic [1:0] REG_INPUTS = 2'd1;
    localparam logic [1:0] REG_OUTPUTS = 2'd2;

    typedef struct packed {
        logic       clr;
        logic       mac;
    } t_mac_ctl;

    localparam logic [1:0] SELB_IV   = 2'd0;
    localparam logic [1:0] SELB_HA   = 2'd1;
    localparam logic [1:0] SELB_BIAS = 2'd2;

    // piecewise-linear sigmoid of the rounded Q16 argument
    function automatic logic [16:0] sigmoid_q16(input logic signed [ACC_W-17:0] z);
        logic [ACC_W-17:0] a;
        logic [16:0]       f;
        a = z[ACC_W-17] ? (ACC_W-16)'(-z) : (ACC_W-16)'(z);
        if (a < (ACC_W-16)'(65536))       f = 17'(a >> 2) + 17'd32768;
        else if (a < (ACC_W-16)'(155648)) f = 17'(a >> 3) + 17'd40960;
        else if (a < (ACC_W-16)'(327680)) f = 17'(a >> 5) + 17'd55296;
        else                               f = 17'd65536;
        return z[ACC_W-17] ? 17'd65536 - f : f;
    endfunction
endpackage
`default_nettype wire

>>> rtl/mlp2_mac.sv
`default_nettype none
module mlp2_mac (
    input  wire logic                            i_clk,
    input  wire mlp2_pkg::t_mac_ctl              i_ctl,
    input  wire logic signed [23:0]              i_a,
    input  wire logic signed [24:0]              i_b,
    output logic signed [mlp2_pkg::ACC_W-1:0]    o_acc
);
    import mlp2_pkg::*;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [48:0]      w_prod;
    assign w_prod = i_a * i_b;
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.mac) begin
            r_acc <= r_acc + ACC_W'(w_prod);
        end
    end
    assign o_acc = r_acc;
endmodule
`default_nettype wire

>>> rtl/mlp_two_layer_sigmoid_forward_core.sv
// Two-layer perceptron forward pass. Load items (weights, input elements)
// are taken one per cycle. An input-element item with last set starts a pass:
// one shared 24x25 multiply-accumulate walks every weight, one product per
// cycle. The pass waits whenever the result side stalls; it is paced by that
// single MAC and the one-read weight memories, and no item is accepted during
// the pass.
// Results leave through an output register, hidden neurons first.
`default_nettype none
module mlp_two_layer_sigmoid_forward_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [5:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // row[4:0] col[10:5] value[34:11]
    input  wire logic [1:0]  s_axis_tuser,  // cmd
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // neuron[4:0] activation[21:5]
    output logic             m_axis_tuser,  // layer
    output logic             m_axis_tlast
);
    import mlp2_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_RUN = 3'd1, ST_DRAIN = 3'd2,
                           ST_ACT = 3'd3, ST_OUT = 3'd4;

    logic [1:0]  w_cmd;  logic [4:0] w_row;  logic [5:0] w_col;
    logic signed [23:0] w_val;
    assign w_cmd = s_axis_tuser;
    assign w_row = s_axis_tdata[4:0];
    assign w_col = s_axis_tdata[10:5];
    assign w_val = s_axis_tdata[34:11];

    logic [5:0] r_hc, r_iw; logic [4:0] r_oc;
    logic [5:0] w_nh, w_ni; logic [4:0] w_no;
    assign w_nh = (r_hc == 0) ? 6'd1 : (r_hc > 6'(MAX_HIDDEN)) ? 6'(MAX_HIDDEN) : r_hc;
    assign w_ni = (r_iw == 0) ? 6'd1 : (r_iw > 6'(MAX_INPUTS)) ? 6'(MAX_INPUTS) : r_iw;
    assign w_no = (r_oc == 0) ? 5'd1 : (r_oc > 5'(MAX_OUTPUTS)) ? 5'(MAX_OUTPUTS) : r_oc;

    logic [2:0] r_st;
    logic       r_layer;
    logic [5:0] r_n, r_j;
    logic       r_vld;           // read issued last cycle
    logic [1:0] r_selb;
    logic       r_ovalid, r_olayer, r_olast;
    logic [4:0] r_oneu;
    logic [16:0] r_oact;

    assign o_cfg_ready   = (r_st == ST_IDLE);
    assign s_axis_tready = (r_st == ST_IDLE);
    wire w_acc_in = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc <= 6'd32; r_iw <= 6'd32; r_oc <= 5'd16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_HIDDEN:  r_hc <= i_cfg_data;
                REG_INPUTS:  r_iw <= i_cfg_data;
                REG_OUTPUTS: r_oc <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // memories
    logic signed [23:0] r_hw [HW_DEPTH];
    logic signed [23:0] r_ow [OW_DEPTH];
    logic signed [23:0] r_iv [MAX_INPUTS];
    logic [16:0]        r_ha [MAX_HIDDEN];
    logic signed [23:0] r_a;
    logic signed [23:0] r_ivq;
    logic [16:0]        r_haq;

    wire w_hw_we = w_acc_in && w_cmd == CMD_HW && w_col < 6'(MAX_INPUTS);
    wire w_ow_we = w_acc_in && w_cmd == CMD_OW && w_row < 5'(MAX_OUTPUTS)
                   && w_col < 6'(OW_COLS);
    wire w_iv_we = w_acc_in && w_cmd == CMD_IV && w_col < 6'(MAX_INPUTS);
    wire [HW_AW-1:0] w_hw_wa = HW_AW'(w_row) * HW_AW'(MAX_INPUTS) + HW_AW'(w_col);
    wire [OW_AW-1:0] w_ow_wa = OW_AW'(w_row) * OW_AW'(OW_COLS) + OW_AW'(w_col);
    wire [HW_AW-1:0] w_hw_ra = HW_AW'(r_n) * HW_AW'(MAX_INPUTS) + HW_AW'(r_j);
    wire [OW_AW-1:0] w_ow_ra = OW_AW'(r_n) * OW_AW'(OW_COLS) + OW_AW'(r_j);

    logic w_ha_we;
    logic signed [ACC_W-1:0] w_acc;
    wire [16:0] w_sig = sigmoid_q16((ACC_W-16)'((w_acc + ACC_W'(32768)) >>> 16));

    always_ff @(posedge i_clk) begin
        if (w_hw_we) r_hw[w_hw_wa] <= w_val;
        if (w_ow_we) r_ow[w_ow_wa] <= w_val;
        if (w_iv_we) r_iv[w_col[IV_AW-1:0]] <= w_val;
        if (w_ha_we) r_ha[r_n[HA_AW-1:0]] <= w_sig;
        r_a   <= r_layer ? r_ow[w_ow_ra] : r_hw[w_hw_ra];
        r_ivq <= r_iv[r_j[IV_AW-1:0]];
        r_haq <= r_ha[r_j[HA_AW-1:0]];
    end

    t_mac_ctl w_ctl;
    logic signed [24:0] w_b;
    always_comb begin
        unique case (r_selb)
            SELB_IV: w_b = 25'(r_ivq);
            SELB_HA: w_b = 25'(signed'({1'b0, r_haq}));
            default: w_b = 25'sd65536;
        endcase
    end
    assign w_ctl.clr   = (r_st == ST_IDLE) || (r_st == ST_OUT && m_axis_tready);
    assign w_ctl.mac   = r_vld;

    mlp2_mac u_mac (.i_clk(i_clk), .i_ctl(w_ctl), .i_a(r_a), .i_b(w_b), .o_acc(w_acc));

    wire [5:0] w_jlast = r_layer ? w_nh : w_ni - 6'd1;
    wire w_final = r_layer && (r_n == 6'(w_no) - 6'd1);
    assign w_ha_we = (r_st == ST_ACT) && !r_layer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_vld <= 1'b0; r_ovalid <= 1'b0;
            r_layer <= 1'b0; r_n <= '0; r_j <= '0; r_selb <= SELB_IV;
        end else begin
            r_vld <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (w_acc_in && w_cmd == CMD_IV && s_axis_tlast) begin
                        r_st <= ST_RUN; r_layer <= 1'b0; r_n <= '0; r_j <= '0;
                    end
                end
                ST_RUN: begin
                    r_vld  <= 1'b1;
                    r_selb <= !r_layer ? SELB_IV : (r_j == w_nh) ? SELB_BIAS : SELB_HA;
                    if (r_j == w_jlast) r_st <= ST_DRAIN;
                    else r_j <= r_j + 6'd1;
                end
                ST_DRAIN: if (!r_vld) r_st <= ST_ACT;
                ST_ACT: begin
                    r_ovalid <= 1'b1; r_olayer <= r_layer; r_oneu <= r_n[4:0];
                    r_oact <= w_sig; r_olast <= w_final;
                    r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_ovalid <= 1'b0; r_j <= '0;
                        if (w_final) begin
                            r_st <= ST_IDLE;
                        end else if (!r_layer && r_n == w_nh - 6'd1) begin
                            r_layer <= 1'b1; r_n <= '0; r_st <= ST_RUN;
                        end else begin
                            r_n <= r_n + 6'd1; r_st <= ST_RUN;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b0, r_oact, r_oneu};
    assign m_axis_tuser  = r_olayer;
    assign m_axis_tlast  = r_olast;

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_st == ST_OUT) else $error("result valid outside output state");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != ST_IDLE |-> !s_axis_tready) else $error("item accepted during pass");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> r_st == ST_IDLE)
        else $error("pass did not end after last result");
endmodule
`default_nettype wire

>>> dv/mlp_two_layer_sigmoid_forward_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module mlp_two_layer_sigmoid_forward_core_tb;
    import mlp2_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int         MAX_SHOWN = 10;

    typedef struct packed {
        logic        layer;
        logic [4:0]  neuron;
        logic [16:0] activation;
        logic        final_res;
    } t_neuron_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [5:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;  // row[4:0] col[10:5] value[34:11]
    logic [1:0]  s_axis_tuser;  // cmd
    logic        s_axis_tlast;  // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;  // neuron[4:0] activation[21:5]
    logic        m_axis_tuser;  // layer
    logic        m_axis_tlast;  // final_res

    mlp_two_layer_sigmoid_forward_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor copy of the network state
    logic signed [23:0] hidden_w [HW_DEPTH];
    logic signed [23:0] output_w [OW_DEPTH];
    logic signed [23:0] in_vec   [MAX_INPUTS];
    logic [16:0]        hidden_act [MAX_HIDDEN];
    logic [5:0]         hidden_reg, inputs_reg;
    logic [4:0]         outputs_reg;

    t_neuron_result pending_results[$];
    int  mismatch_count;
    int  gap_pct, stall_pct;
    int  hold_req;
    int  hold_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("** mlp_two_layer_sigmoid_forward_core: FAILED **");
        $finish;
    end

    function automatic int eff_count(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [16:0] sigmoid_pwl(longint z);
        longint a;
        longint f;
        a = (z < 0) ? -z : z;
        if (a < 65536) f = (a >> 2) + 32768;
        else if (a < 155648) f = (a >> 3) + 40960;
        else if (a < 327680) f = (a >> 5) + 55296;
        else f = 65536;
        if (z < 0) f = 65536 - f;
        return 17'(f);
    endfunction

    function automatic logic [16:0] activate(longint acc);
        longint z;
        z = (acc + 32768) >>> 16;
        return sigmoid_pwl(z);
    endfunction

    // apply one accepted item to the state; a pass queues its results
    task automatic predict_item(logic [1:0] cmd, logic [4:0] row, logic [5:0] col,
                                logic signed [23:0] value, logic last);
        int nh, ni, no;
        longint acc;
        t_neuron_result r;
        case (cmd)
            CMD_HW: begin
                if (col < MAX_INPUTS) hidden_w[row * MAX_INPUTS + col] = value;
            end
            CMD_OW: begin
                if (row < MAX_OUTPUTS && col < OW_COLS) output_w[row * OW_COLS + col] = value;
            end
            CMD_IV: begin
                if (col < MAX_INPUTS) in_vec[col] = value;
                if (last) begin
                    nh = eff_count(hidden_reg, MAX_HIDDEN);
                    ni = eff_count(inputs_reg, MAX_INPUTS);
                    no = eff_count(outputs_reg, MAX_OUTPUTS);
                    for (int h = 0; h < nh; h++) begin
                        acc = 0;
                        for (int j = 0; j < ni; j++)
                            acc += longint'(hidden_w[h * MAX_INPUTS + j]) * longint'(in_vec[j]);
                        hidden_act[h] = activate(acc);
                        r = '{1'b0, 5'(h), hidden_act[h], 1'b0};
                        pending_results.push_back(r);
                    end
                    for (int o = 0; o < no; o++) begin
                        acc = 0;
                        for (int j = 0; j < nh; j++)
                            acc += longint'(output_w[o * OW_COLS + j]) * longint'(hidden_act[j]);
                        acc += longint'(output_w[o * OW_COLS + nh]) * 65536;
                        r = '{1'b1, 5'(o), activate(acc), 1'b0};
                        pending_results.push_back(r);
                    end
                    pending_results[$].final_res = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(logic [1:0] cmd, logic [4:0] row, logic [5:0] col,
                             logic signed [23:0] value, logic last);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, value, col, row};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(cmd, row, col, value, last);
    endtask

    task automatic wait_drained(int settle);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [5:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            REG_HIDDEN:  hidden_reg  = data;
            REG_INPUTS:  inputs_reg  = data;
            REG_OUTPUTS: outputs_reg = data[4:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_shape(logic [5:0] nh, logic [5:0] ni, logic [5:0] no);
        wait_drained(40);
        write_reg(REG_HIDDEN, nh);
        write_reg(REG_INPUTS, ni);
        write_reg(REG_OUTPUTS, no);
    endtask

    function automatic logic signed [23:0] pick_value();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return 24'($signed($urandom_range(131072)) - 65536);
            2: return 24'($signed($urandom_range(8192)) - 4096);
            default: return 24'($signed($urandom_range(40000)) - 20000);
        endcase
    endfunction

    // fill every entry a pass can read so that no store is read unwritten
    task automatic test_preload();
        for (int r = 0; r < MAX_HIDDEN; r++)
            for (int c = 0; c < MAX_INPUTS; c++)
                send_item(CMD_HW, 5'(r), 6'(c), pick_value(), 1'b0);
        for (int r = 0; r < MAX_OUTPUTS; r++)
            for (int c = 0; c < OW_COLS; c++)
                send_item(CMD_OW, 5'(r), 6'(c), pick_value(), 1'b0);
        for (int c = 0; c < MAX_INPUTS; c++)
            send_item(CMD_IV, 5'(0), 6'(c), pick_value(), c == MAX_INPUTS - 1);
    endtask

    task automatic test_directed();
        send_item(CMD_HW, 5'd31, 6'd31, 24'sh7FFFFF, 1'b0);
        send_item(CMD_HW, 5'd0, 6'd0, 24'sh800000, 1'b0);
        send_item(CMD_HW, 5'd3, 6'd32, 24'sh123456, 1'b0);
        send_item(CMD_HW, 5'd3, 6'd63, 24'sh654321, 1'b0);
        send_item(CMD_OW, 5'd16, 6'd0, 24'sh7FFFFF, 1'b0);
        send_item(CMD_OW, 5'd31, 6'd5, 24'sh800000, 1'b0);
        send_item(CMD_OW, 5'd2, 6'd33, 24'sh0ABCDE, 1'b0);
        send_item(CMD_OW, 5'd15, 6'd32, 24'sh800000, 1'b0);
        send_item(CMD_NONE, 5'd31, 6'd63, 24'shFFFFFF, 1'b1);
        send_item(CMD_IV, 5'd31, 6'd31, 24'sh7FFFFF, 1'b0);
        send_item(CMD_IV, 5'd0, 6'd0, 24'sh010000, 1'b0);
        // ignored element write still starts the pass
        send_item(CMD_IV, 5'd0, 6'd40, 24'sh7FFFFF, 1'b1);
        send_item(CMD_IV, 5'd0, 6'd1, 24'sh800000, 1'b1);
        set_shape(6'd0, 6'd0, 6'd0);
        send_item(CMD_IV, 5'd0, 6'd0, 24'sh008000, 1'b1);
        set_shape(6'd63, 6'd63, 6'd63);
        send_item(CMD_IV, 5'd0, 6'd63, 24'sh000000, 1'b1);
        set_shape(6'd1, 6'd32, 6'd16);
        send_item(CMD_IV, 5'd0, 6'd2, 24'shFF0000, 1'b1);
        wait_drained(1);
    endtask

    task automatic test_random_phase(int gap, int stall, int n_items,
                                     logic [5:0] nh, logic [5:0] ni, logic [5:0] no);
        int sent;
        int r;
        set_shape(nh, ni, no);
        gap_pct   = gap;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 5) begin
                send_item(CMD_NONE, 5'($urandom), 6'($urandom), 24'($urandom), 1'($urandom));
            end else begin
                sent++;
                if (r < 35)
                    send_item(CMD_HW, 5'($urandom), 6'($urandom_range(r < 8 ? 63 : 35)),
                              pick_value(), 1'($urandom));
                else if (r < 60)
                    send_item(CMD_OW, 5'($urandom_range(r < 38 ? 31 : 17)),
                              6'($urandom_range(r < 38 ? 63 : 34)), pick_value(), 1'($urandom));
                else if (r < 88)
                    send_item(CMD_IV, 5'($urandom), 6'($urandom_range(r < 62 ? 63 : 33)),
                              pick_value(), 1'b0);
                else
                    send_item(CMD_IV, 5'($urandom), 6'($urandom_range(r < 90 ? 63 : 31)),
                              pick_value(), 1'b1);
            end
        end
        wait_drained(1);
    endtask

    // hold the result side off while loads and passes keep coming
    task automatic test_backpressure();
        set_shape(6'd6, 6'd5, 6'd4);
        gap_pct   = 0;
        stall_pct = 0;
        hold_req  = 1500;
        for (int k = 0; k < 12; k++)
            send_item(CMD_IV, 5'd0, 6'($urandom_range(4)), pick_value(), k % 4 == 3);
        wait_drained(1);
        send_item(CMD_IV, 5'd0, 6'd0, pick_value(), 1'b1);
        wait_drained(1);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_neuron_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[21:5], m_axis_tlast};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected result: layer %0d neuron %0d act %0d last %0d",
                             got.layer, got.neuron, got.activation, got.final_res);
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display({"mismatch: exp layer %0d neuron %0d act %0d last %0d,",
                                  " got %0d %0d %0d %0d"},
                                 want.layer, want.neuron, want.activation, want.final_res,
                                 got.layer, got.neuron, got.activation, got.final_res);
                end
            end
        end
    end

    // result-side ready with random stalls and long hold-offs
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_HIDDEN;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_HW;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        hidden_reg    = 6'd32;
        inputs_reg    = 6'd32;
        outputs_reg   = 5'd16;
        mismatch_count = 0;
        gap_pct   = 0;
        stall_pct = 0;
        hold_req  = 0;
        hold_left = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_preload();
        test_directed();
        test_random_phase(0, 0, 110, 6'd3, 6'd4, 6'd2);
        test_random_phase(50, 0, 110, 6'd0, 6'd0, 6'd0);
        test_random_phase(0, 50, 100, 6'd5, 6'd7, 6'd16);
        test_random_phase(27, 27, 60, 6'd32, 6'd32, 6'd16);
        test_random_phase(27, 27, 60, 6'd2, 6'd3, 6'd1);
        test_backpressure();

        wait_drained(100);
        if (mismatch_count == 0)
            $display("** mlp_two_layer_sigmoid_forward_core: PASSED **");
        else
            $display("** mlp_two_layer_sigmoid_forward_core: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
